>>> design/utf8d_pkg.sv
// Shared types and constants for the UTF-8 decoder with control filter.
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PointW = 21;
  localparam int unsigned RemW   = 2;

  localparam logic [ByteW-1:0] ChTab   = 8'd9;
  localparam logic [ByteW-1:0] ChLf    = 8'd10;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChDel   = 8'd127;

  typedef struct packed {
    logic [RemW-1:0]   rem;
    logic [PointW-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic [PointW-1:0] code_point;
    logic              point_valid;
    logic              end_of_text;
  } dec_result_t;

endpackage

>>> design/utf8d_step.sv
// Combinational decode of one byte against the current sequence state.
module utf8d_step (
  input  utf8d_pkg::dec_state_t  state_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  output utf8d_pkg::dec_state_t  state_o,
  output utf8d_pkg::dec_result_t result_o
);
  import utf8d_pkg::*;

  logic              is_cont;
  logic              as_lead;
  logic              done;
  logic              keep;
  logic [PointW-1:0] cp;
  logic [PointW-1:0] cont_point;
  logic [RemW-1:0]   cont_rem;
  dec_state_t        nxt;

  assign is_cont    = (byte_i[7:6] == 2'b10);
  assign cont_point = {state_i.partial[PointW-7:0], byte_i[5:0]};
  assign cont_rem   = state_i.rem - RemW'(1);

  always_comb begin
    nxt     = state_i;
    as_lead = 1'b1;
    done    = 1'b0;
    cp      = '0;
    if (state_i.rem != '0) begin
      if (is_cont) begin
        as_lead     = 1'b0;
        nxt.rem     = cont_rem;
        nxt.partial = cont_point;
        if (cont_rem == '0) begin
          cp          = cont_point;
          nxt.partial = '0;
          done        = 1'b1;
        end
      end else begin
        nxt = '0;
      end
    end
    if (as_lead) begin
      priority if (byte_i[7] == 1'b0) begin
        cp   = PointW'(byte_i);
        done = 1'b1;
      end else if (byte_i[7:5] == 3'b110) begin
        nxt.rem     = RemW'(1);
        nxt.partial = PointW'(byte_i[4:0]);
      end else if (byte_i[7:4] == 4'b1110) begin
        nxt.rem     = RemW'(2);
        nxt.partial = PointW'(byte_i[3:0]);
      end else if (byte_i[7:3] == 5'b11110) begin
        nxt.rem     = RemW'(3);
        nxt.partial = PointW'(byte_i[2:0]);
      end else begin
        // malformed lead or stray continuation: dropped
      end
    end
    // control filter
    keep = done;
    if (cp == PointW'(ChTab)) begin
      cp = PointW'(ChSpace);
    end else if (cp < PointW'(ChSpace) || cp == PointW'(ChDel)) begin
      keep = 1'b0;
    end
    if (!keep) begin
      cp = '0;
    end
    if (last_i) begin
      nxt = '0;
    end
  end

  assign state_o              = nxt;
  assign result_o.code_point  = cp;
  assign result_o.point_valid = keep;
  assign result_o.end_of_text = last_i;

endmodule

>>> design/utf8_decoder_with_control_filter_top.sv
// Top level: UTF-8 byte decoder with control-character filter and output register.
// Takes one byte per cycle and gives one result per byte, registered in the
// cycle after the byte's transfer and held in an output register until it is
// taken. Throughput is one byte per clock: the sequence state (continuation count
// and partial code point) is updated in the same cycle the byte is transferred,
// and the output register accepts a new result in the cycle its current result
// is taken, so in_stall_o is high only while a result waits and out_stall_i is high.
module utf8_decoder_with_control_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        point_valid_o,
  output logic        end_of_text_o
);
  import utf8d_pkg::*;

  dec_state_t  state_q, state_d;
  dec_result_t res_q, res_d;
  logic        out_valid_q;
  logic        in_xfer;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  utf8d_step u_step (
    .state_i  (state_q),
    .byte_i   (byte_in_i),
    .last_i   (last_in_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = res_q.code_point;
  assign point_valid_o = res_q.point_valid;
  assign end_of_text_o = res_q.end_of_text;

  a_filtered_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_valid_o) |->
      (code_point_o >= 21'd32 && code_point_o != 21'd127 &&
       code_point_o != 21'd0))
    else $error("filtered code point reported as valid");

  a_dropped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !point_valid_o) |-> (code_point_o == '0))
    else $error("dropped result carries nonzero code point");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_in_i) |=> (state_q == '0))
    else $error("sequence state not cleared after end of string");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(res_q)))
    else $error("stalled result lost or changed");

endmodule
